// ----- rtl/core/pxd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pxd_pkg;

  // readout word types, top four bits
  localparam logic [3:0] TYPE_POWER = 4'h0;
  localparam logic [3:0] TYPE_HEART = 4'h4;
  localparam logic [3:0] TYPE_TRIG  = 4'h6;
  localparam logic [3:0] TYPE_PIX_A = 4'hA;
  localparam logic [3:0] TYPE_PIX_B = 4'hB;

  // subtypes, bits 59..56
  localparam logic [3:0] SUB_HB_LOW  = 4'h4;
  localparam logic [3:0] SUB_HB_HIGH = 4'h5;
  localparam logic [3:0] SUB_POWER   = 4'h6;
  localparam logic [3:0] SUB_TRIG    = 4'hF;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CFG_POWER_EN    = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_TIME_OFFSET = 1'd1;

  localparam logic [63:0] CLEAR_LIMIT = 64'd983040000000;
  localparam logic [35:0] TDC_JUMP    = 36'h0_1312_d000;
  localparam logic [63:0] HALF_WRAP   = 64'h0000_0200_0000_0000;

  typedef enum logic [2:0] {
    KIND_PIXEL       = 3'd0,
    KIND_TRIGGER     = 3'd1,
    KIND_POWER_ON    = 3'd2,
    KIND_POWER_OFF   = 3'd3,
    KIND_SHUTTER_OPN = 3'd4,
    KIND_SHUTTER_CLS = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         column;
    logic [7:0]         pixel_row;
    logic [9:0]         tot;
    logic signed [63:0] time_ticks;
    logic [3:0]         fine_stamp;
    logic [11:0]        trigger_count;
    logic               last;
  } rec_t;

  typedef struct packed {
    logic [63:0] sync_time;
    logic        header_cleared;
    logic [34:0] last_tdc_stamp;
    logic [28:0] tdc_wraps;
    logic        shutter_is_open;
  } state_t;

  typedef struct packed {
    logic [1:0] n;
    rec_t       r0;
    rec_t       r1;
  } dec_t;

endpackage

`default_nettype wire

// ----- rtl/core/pxd_pkt_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pxd_pkt_if;
  logic        valid;
  logic        ready;
  logic [63:0] packet;

  modport source (output valid, output packet, input ready);
  modport sink (input valid, input packet, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pxd_rec_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pxd_rec_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [7:0]         column;
  logic [7:0]         pixel_row;
  logic [9:0]         tot;
  logic signed [63:0] time_ticks;
  logic [3:0]         fine_stamp;
  logic [11:0]        trigger_count;
  logic               last;

  modport source (
    output valid, output kind, output column, output pixel_row, output tot,
    output time_ticks, output fine_stamp, output trigger_count, output last,
    input ready
  );
  modport sink (
    input valid, input kind, input column, input pixel_row, input tot,
    input time_ticks, input fine_stamp, input trigger_count, input last,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/pxd_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pxd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pxd_pkg::CfgIdxW-1:0]   index;
  logic [pxd_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pxd_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pxd_decode (
  input  logic [63:0]         pkt,
  input  pxd_pkg::state_t     st,
  input  logic                power_pulse_enable,
  input  logic signed [31:0]  time_offset_ticks,
  output pxd_pkg::dec_t       dec,
  output pxd_pkg::state_t     st_next
);

  logic [3:0]  ptype;
  logic [3:0]  sub;
  logic [63:0] sync_high;

  // pixel fields
  logic [6:0]  dcol;
  logic [6:0]  dcol_m1;
  logic [7:0]  col;
  logic [7:0]  row;
  logic [63:0] t_base;
  logic [12:0] phase;
  logic [32:0] adj;
  logic [63:0] t_sum;
  logic [63:0] sync_diff;
  logic        pix_wrap;
  logic [63:0] t_pix;

  // trigger fields
  logic [34:0] raw;
  logic [35:0] tdiff;
  logic        tdc_jump;
  logic [28:0] wraps_new;

  // power pulse fields
  logic [63:0] t_pow;
  pxd_pkg::kind_t pow_kind;

  assign ptype = pkt[63:60];
  assign sub   = pkt[59:56];
  assign sync_high = {4'h0, pkt[31:16], st.sync_time[43:0]};

  assign dcol    = pkt[59:53];
  assign dcol_m1 = dcol - 7'd1;
  assign col     = {pkt[59:53], pkt[46]};
  assign row     = {pkt[52:47], pkt[45:44]};
  assign t_base  = {st.sync_time[63:42], pkt[15:0], pkt[43:30], ~pkt[19:16], 8'h00};
  // first double column sits one phase step early
  assign phase   = (dcol == 7'd0) ? 13'h1F00 : {1'b0, dcol_m1[3:0], 8'h00};
  assign adj     = {time_offset_ticks[31], time_offset_ticks} + {{20{phase[12]}}, phase};
  assign t_sum   = t_base + {{31{adj[32]}}, adj};
  assign sync_diff = st.sync_time - t_sum;
  assign pix_wrap  = !sync_diff[63] && (sync_diff > pxd_pkg::HALF_WRAP);
  assign t_pix     = pix_wrap ? {t_sum[63:42] + 22'd1, t_sum[41:0]} : t_sum;

  assign raw       = pkt[43:9];
  assign tdiff     = {1'b0, st.last_tdc_stamp} - {1'b0, raw};
  assign tdc_jump  = !tdiff[35] && (tdiff > pxd_pkg::TDC_JUMP);
  assign wraps_new = tdc_jump ? st.tdc_wraps + 29'd1 : st.tdc_wraps;

  assign t_pow    = {16'h0000, pkt[35:0], 12'h000};
  assign pow_kind = pkt[53] ? pxd_pkg::KIND_POWER_ON : pxd_pkg::KIND_POWER_OFF;

  always_comb begin
    st_next = st;
    dec     = '0;
    case (ptype)
      pxd_pkg::TYPE_HEART: begin
        if (pkt[55:48] == 8'h00) begin
          case (sub)
            pxd_pkg::SUB_HB_LOW: begin
              st_next.sync_time = {st.sync_time[63:44], pkt[47:16], 12'h000};
            end
            pxd_pkg::SUB_HB_HIGH: begin
              st_next.sync_time = sync_high;
              if (sync_high < pxd_pkg::CLEAR_LIMIT) begin
                st_next.header_cleared = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      pxd_pkg::TYPE_POWER: begin
        if (st.header_cleared && sub == pxd_pkg::SUB_POWER && power_pulse_enable) begin
          dec.r0.kind       = pow_kind;
          dec.r0.time_ticks = t_pow;
          dec.r1.time_ticks = t_pow;
          dec.r1.last       = 1'b1;
          if (!pkt[52]) begin
            dec.n       = 2'd2;
            dec.r1.kind = pxd_pkg::KIND_SHUTTER_OPN;
            st_next.shutter_is_open = 1'b1;
          end else if (st.shutter_is_open) begin
            dec.n       = 2'd2;
            dec.r1.kind = pxd_pkg::KIND_SHUTTER_CLS;
            st_next.shutter_is_open = 1'b0;
          end else begin
            dec.n       = 2'd1;
            dec.r0.last = 1'b1;
          end
        end
      end
      pxd_pkg::TYPE_TRIG: begin
        if (st.header_cleared && sub == pxd_pkg::SUB_TRIG && pkt[4:0] == 5'd0) begin
          st_next.tdc_wraps      = wraps_new;
          st_next.last_tdc_stamp = raw;
          dec.n                  = 2'd1;
          dec.r0.kind            = pxd_pkg::KIND_TRIGGER;
          dec.r0.time_ticks      = {wraps_new, raw};
          dec.r0.fine_stamp      = pkt[8:5];
          dec.r0.trigger_count   = pkt[55:44];
          dec.r0.last            = 1'b1;
        end
      end
      pxd_pkg::TYPE_PIX_A, pxd_pkg::TYPE_PIX_B: begin
        if (st.header_cleared) begin
          dec.n                = 2'd1;
          dec.r0.kind          = pxd_pkg::KIND_PIXEL;
          dec.r0.column        = col;
          dec.r0.pixel_row     = row;
          dec.r0.tot           = pkt[29:20];
          dec.r0.time_ticks    = t_pix;
          dec.r0.last          = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/pixel_detector_packet_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   modport  handshake     payload
// packets   sink     valid/ready   packet[63:0]
// records   source   valid/ready   kind, column, pixel_row, tot, time_ticks,
//                                  fine_stamp, trigger_count, last
// cfg       sink     valid/ready   index, data[31:0], ready always high
//
// a packet is held in the input register and decoded into the two-entry
// result register: one packet per cycle while records.ready stays high.
// packets with two records hold the input register while the second
// record drains. rst is synchronous and clears all decode state,
// the sync time and both configuration registers. a stalled records channel
// stalls packets once the result register cannot take the next decode.

module pixel_detector_packet_decoder (
  input  logic     clk,
  input  logic     rst,
  pxd_pkt_if.sink  packets,
  pxd_rec_if.source records,
  pxd_cfg_if.sink  cfg
);

  logic               power_pulse_enable;
  logic signed [31:0] time_offset_ticks;

  logic        s1_valid;
  logic [63:0] s1_pkt;

  pxd_pkg::state_t st;
  pxd_pkg::state_t st_next;
  pxd_pkg::dec_t   dec;

  pxd_pkg::rec_t rec0;
  pxd_pkg::rec_t rec1;
  logic [1:0]    cnt;

  logic in_fire;
  logic out_fire;
  logic adv;

  assign out_fire = records.valid && records.ready;
  assign adv      = s1_valid && (cnt == 2'd0 || (cnt == 2'd1 && out_fire));
  assign packets.ready = !s1_valid || adv;
  assign in_fire  = packets.valid && packets.ready;
  assign cfg.ready = 1'b1;

  pxd_decode u_decode (
    .pkt                (s1_pkt),
    .st                 (st),
    .power_pulse_enable (power_pulse_enable),
    .time_offset_ticks  (time_offset_ticks),
    .dec                (dec),
    .st_next            (st_next)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      power_pulse_enable <= 1'b0;
      time_offset_ticks  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        pxd_pkg::CFG_POWER_EN: begin
          power_pulse_enable <= cfg.data[0];
        end
        pxd_pkg::CFG_TIME_OFFSET: begin
          time_offset_ticks <= cfg.data;
        end
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
    if (in_fire) begin
      s1_pkt <= packets.packet;
    end
  end

  // decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (adv) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (adv && dec.n != 2'd0) begin
      cnt <= dec.n;
    end else if (out_fire) begin
      cnt <= cnt - 2'd1;
    end
    if (adv && dec.n != 2'd0) begin
      rec0 <= dec.r0;
      rec1 <= dec.r1;
    end else if (out_fire) begin
      rec0 <= rec1;
    end
  end

  assign records.valid         = (cnt != 2'd0);
  assign records.kind          = rec0.kind;
  assign records.column        = rec0.column;
  assign records.pixel_row     = rec0.pixel_row;
  assign records.tot           = rec0.tot;
  assign records.time_ticks    = rec0.time_ticks;
  assign records.fine_stamp    = rec0.fine_stamp;
  assign records.trigger_count = rec0.trigger_count;
  assign records.last          = rec0.last;

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("result count out of range");

  a_first_has_partner: assert property (@(posedge clk) disable iff (rst)
    records.valid && !records.last |-> cnt == 2'd2)
    else $error("non-final record without its partner");

  a_no_result_before_clear: assert property (@(posedge clk) disable iff (rst)
    adv && !st.header_cleared |-> dec.n == 2'd0)
    else $error("record produced before header cleared");

  a_cleared_sticks: assert property (@(posedge clk) disable iff (rst)
    !$fell(st.header_cleared))
    else $error("header cleared flag dropped");

endmodule

`default_nettype wire

// ----- tb/sv/tb_pixel_detector_packet_decoder.sv -----
`timescale 1ns / 1ps

module tb_pixel_detector_packet_decoder;
  import pxd_pkg::*;

  localparam int SETTLE_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst;

  pxd_pkt_if pkt_ch ();
  pxd_rec_if rec_ch ();
  pxd_cfg_if cfg_ch ();

  pixel_detector_packet_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .packets(pkt_ch),
    .records(rec_ch),
    .cfg    (cfg_ch)
  );

  always #1 clk = ~clk;

  // decoder state as the testbench tracks it
  logic [63:0] exp_sync = '0;
  logic        exp_cleared = 1'b0;
  logic [34:0] exp_tdc_last = '0;
  logic [28:0] exp_tdc_wraps = '0;
  logic        exp_shutter_open = 1'b0;
  logic        exp_power_en = 1'b0;
  logic [31:0] exp_offset = '0;

  rec_t expected_records[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int err_count = 0;
  int unsigned cycle_count = 0;

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pixel_fields(input logic [7:0] col, input logic [7:0] row,
                                               input logic [9:0] tot, input logic [13:0] toa,
                                               input logic [3:0] ftoa, input logic [15:0] coarse);
    return {TYPE_PIX_A, col[7:1], row[7:2], col[0], row[1:0], toa, tot, ftoa, coarse};
  endfunction

  function automatic logic [63:0] trig_word(input logic [34:0] raw);
    logic [63:0] r;
    r = rand64();
    return {TYPE_TRIG, SUB_TRIG, r[11:0], raw, r[15:12], 5'd0};
  endfunction

  function automatic logic [63:0] power_word(input logic [3:0] sub, input logic [3:0] ctrl);
    logic [63:0] r;
    r = rand64();
    return {TYPE_POWER, sub, ctrl, r[51:0]};
  endfunction

  function automatic logic [63:0] hb_word(input logic [3:0] sub, input logic [7:0] gap,
                                          input logic [31:0] v);
    logic [31:0] r;
    r = $urandom();
    return {TYPE_HEART, sub, gap, v, r[15:0]};
  endfunction

  task automatic add_expected(input rec_t r);
    expected_records = {expected_records, r};
  endtask

  task automatic decode_packet(input logic [63:0] w);
    rec_t rec;
    logic [63:0] t;
    logic [63:0] diff;
    logic [34:0] raw;
    logic [6:0] dcol_m1;
    logic [3:0] ftoa_inv;
    rec = '0;
    rec.last = 1'b1;
    if (w[63:60] == TYPE_HEART) begin
      if (w[55:48] == 8'd0 && w[59:56] == SUB_HB_LOW) begin
        exp_sync = {exp_sync[63:44], w[47:16], 12'd0};
      end else if (w[55:48] == 8'd0 && w[59:56] == SUB_HB_HIGH) begin
        exp_sync = {4'd0, w[31:16], exp_sync[43:0]};
        if (exp_sync < CLEAR_LIMIT) exp_cleared = 1'b1;
      end
    end else if (exp_cleared) begin
      case (w[63:60])
        TYPE_POWER: begin
          if (w[59:56] == SUB_POWER && exp_power_en) begin
            if (w[53]) rec.kind = KIND_POWER_ON;
            else rec.kind = KIND_POWER_OFF;
            rec.time_ticks = {16'd0, w[35:0], 12'd0};
            if (!w[52] || exp_shutter_open) begin
              rec.last = 1'b0;
              add_expected(rec);
              if (w[52]) rec.kind = KIND_SHUTTER_CLS;
              else rec.kind = KIND_SHUTTER_OPN;
              rec.last = 1'b1;
              exp_shutter_open = !w[52];
            end
            add_expected(rec);
          end
        end
        TYPE_TRIG: begin
          if (w[59:56] == SUB_TRIG && w[4:0] == 5'd0) begin
            raw = w[43:9];
            diff = {29'd0, exp_tdc_last} - {29'd0, raw};
            if (!diff[63] && diff > {28'd0, TDC_JUMP}) exp_tdc_wraps = exp_tdc_wraps + 29'd1;
            exp_tdc_last = raw;
            rec.kind = KIND_TRIGGER;
            rec.time_ticks = {exp_tdc_wraps, raw};
            rec.fine_stamp = w[8:5];
            rec.trigger_count = w[55:44];
            add_expected(rec);
          end
        end
        TYPE_PIX_A, TYPE_PIX_B: begin
          rec.kind = KIND_PIXEL;
          rec.column = {w[59:53], w[46]};
          rec.pixel_row = {w[52:47], w[45:44]};
          rec.tot = w[29:20];
          ftoa_inv = 4'd15 - w[19:16];
          t = {22'd0, w[15:0], w[43:30], ftoa_inv, 8'd0} + {exp_sync[63:42], 42'd0};
          // column phase, the first double column sits one step early
          dcol_m1 = w[59:53] - 7'd1;
          if (w[59:53] == 7'd0) t = t - 64'd256;
          else t = t + {52'd0, dcol_m1[3:0], 8'd0};
          t = t + {{32{exp_offset[31]}}, exp_offset};
          diff = exp_sync - t;
          if (!diff[63] && diff > HALF_WRAP) t = t + (HALF_WRAP << 1);
          rec.time_ticks = t;
          add_expected(rec);
        end
        default: ;
      endcase
    end
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    err_count++;
    $display("mismatch %s: got %h expected %h at cycle %0d", field, got, want, cycle_count);
  endtask

  task automatic send_packet(input logic [63:0] word);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      pkt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pkt_ch.valid <= 1'b1;
    pkt_ch.packet <= word;
    @(negedge clk);
    while (!pkt_ch.ready) @(negedge clk);
    @(posedge clk);
    decode_packet(word);
  endtask

  task automatic drain_records();
    pkt_ch.valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic en, input logic [31:0] offset);
    logic [31:0] junk;
    junk = $urandom();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_POWER_EN;
    cfg_ch.data <= {junk[31:1], en};
    @(negedge clk);
    while (!cfg_ch.ready) @(negedge clk);
    @(posedge clk);
    exp_power_en = en;
    cfg_ch.index <= CFG_TIME_OFFSET;
    cfg_ch.data <= offset;
    @(negedge clk);
    while (!cfg_ch.ready) @(negedge clk);
    @(posedge clk);
    exp_offset = offset;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic pick_random_packet(output logic [63:0] w);
    int sel;
    logic [63:0] r;
    logic [34:0] raw;
    logic [3:0] sub;
    sel = $urandom_range(99);
    r = rand64();
    if (sel < 32) begin
      if (r[0]) w = {TYPE_PIX_A, r[63:4]};
      else w = {TYPE_PIX_B, r[63:4]};
    end else if (sel < 50) begin
      case ($urandom_range(3))
        0, 1: raw = exp_tdc_last + $urandom_range(1, 32'h0200_0000);
        2: raw = exp_tdc_last - TDC_JUMP[34:0] + $urandom_range(2) - 35'd1;
        default: raw = r[34:0];
      endcase
      w = trig_word(raw);
    end else if (sel < 65) begin
      w = power_word(SUB_POWER, r[3:0]);
    end else if (sel < 72) begin
      w = hb_word(SUB_HB_LOW, 8'd0, r[31:0]);
    end else if (sel < 79) begin
      w = hb_word(SUB_HB_HIGH, 8'd0, r[31:0]);
    end else begin
      case ($urandom_range(4))
        0: w = r;
        1: w = trig_word(r[34:0]) | 64'($urandom_range(1, 31));
        2: begin
          if (r[4]) sub = SUB_HB_LOW;
          else sub = SUB_HB_HIGH;
          w = hb_word(sub, 8'($urandom_range(1, 255)), r[63:32]);
        end
        3: begin
          sub = r[7:4];
          if (sub == SUB_POWER) sub = SUB_TRIG;
          w = power_word(sub, r[3:0]);
        end
        default: begin
          sub = r[7:4];
          if (sub == SUB_TRIG) sub = SUB_POWER;
          w = {TYPE_TRIG, sub, r[55:0]};
        end
      endcase
    end
  endtask

  task automatic test_startup_gate();
    send_packet(pixel_fields(8'd10, 8'd20, 10'd5, 14'd100, 4'd3, 16'd7));
    send_packet(trig_word(35'd12345));
    // sync lands exactly on the start threshold
    send_packet(hb_word(SUB_HB_LOW, 8'd0, 32'h0E4E_1C00));
    send_packet(hb_word(SUB_HB_HIGH, 8'd0, 32'hFFFF_0000));
    send_packet(power_word(SUB_POWER, 4'b0010));
    send_packet(hb_word(SUB_HB_LOW, 8'd0, 32'h0E4E_1BFF));
    // gap bits set, must not clear
    send_packet(hb_word(SUB_HB_HIGH, 8'h80, 32'h0000_0000));
    send_packet(trig_word(35'd999));
    send_packet(hb_word(SUB_HB_HIGH, 8'd0, 32'h0000_0001));
    send_packet(pixel_fields(8'd40, 8'd41, 10'd6, 14'd7, 4'd8, 16'd9));
    send_packet(hb_word(SUB_TRIG, 8'd0, 32'h0000_0000));
    send_packet(hb_word(SUB_HB_HIGH, 8'd0, 32'h0000_0000));
    // reset register values: power pulses off, zero offset
    send_packet(power_word(SUB_POWER, 4'b0010));
    send_packet(pixel_fields(8'd100, 8'd50, 10'd300, 14'h1234, 4'd9, 16'hABCD));
    drain_records();
  endtask

  task automatic test_directed_decode();
    program_regs(1'b1, 32'h8000_0000);
    send_packet(pixel_fields(8'd0, 8'd0, 10'h3FF, 14'd0, 4'd0, 16'h0000));
    send_packet(pixel_fields(8'd1, 8'd255, 10'd0, 14'h3FFF, 4'hF, 16'hFFFF));
    send_packet(pixel_fields(8'd2, 8'd3, 10'd512, 14'h2000, 4'd7, 16'h8000));
    send_packet(pixel_fields(8'd35, 8'd128, 10'd1, 14'd1, 4'd1, 16'd1));
    send_packet({TYPE_PIX_B, 60'hFFF_FFFF_FFFF_FFFF});
    send_packet({TYPE_TRIG, SUB_TRIG, 12'hFFF, 35'h7_FFFF_FFFF, 4'hF, 5'd0});
    // step back by exactly the jump, then by one more than it
    send_packet(trig_word(35'h7_FFFF_FFFF - TDC_JUMP[34:0]));
    send_packet(trig_word(35'h7_FFFF_FFFF - 2 * TDC_JUMP[34:0] - 35'd1));
    send_packet(trig_word(35'd0) | 64'd1);
    send_packet({TYPE_TRIG, SUB_HB_LOW, 56'h00_1234_5678_9ABC});
    send_packet(power_word(SUB_POWER, 4'b0010));
    send_packet(power_word(SUB_POWER, 4'b0001));
    send_packet(power_word(SUB_POWER, 4'b0011));
    send_packet(power_word(SUB_POWER, 4'b1100));
    send_packet(power_word(SUB_HB_LOW, 4'b0010));
    drain_records();
  endtask

  task automatic test_backpressure();
    logic [63:0] w;
    send_idle_pct = 0;
    stall_pct = 0;
    program_regs(1'b1, 32'hFFFF_FFFF);
    hold_left = 300;
    repeat (60) begin
      pick_random_packet(w);
      send_packet(w);
    end
    drain_records();
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct, input int stall,
                                     input logic en, input logic [31:0] offset);
    int done;
    logic [63:0] w;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    program_regs(en, offset);
    done = 0;
    while (done < n_items) begin
      pick_random_packet(w);
      send_packet(w);
      done++;
    end
    drain_records();
  endtask

  initial begin
    rec_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rec_ch.ready <= 1'b0;
      end else begin
        rec_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(negedge clk) begin : record_check
    rec_t want;
    if (!rst && rec_ch.valid && rec_ch.ready) begin
      if (expected_records.size() == 0) begin
        report_mismatch("record with no transaction pending", rec_ch.time_ticks, '0);
      end else begin
        want = expected_records.pop_front();
        if (rec_ch.kind !== want.kind)
          report_mismatch("kind", 64'(rec_ch.kind), 64'(want.kind));
        if (rec_ch.column !== want.column)
          report_mismatch("column", 64'(rec_ch.column), 64'(want.column));
        if (rec_ch.pixel_row !== want.pixel_row)
          report_mismatch("pixel_row", 64'(rec_ch.pixel_row), 64'(want.pixel_row));
        if (rec_ch.tot !== want.tot)
          report_mismatch("tot", 64'(rec_ch.tot), 64'(want.tot));
        if (rec_ch.time_ticks !== want.time_ticks)
          report_mismatch("time_ticks", rec_ch.time_ticks, want.time_ticks);
        if (rec_ch.fine_stamp !== want.fine_stamp)
          report_mismatch("fine_stamp", 64'(rec_ch.fine_stamp), 64'(want.fine_stamp));
        if (rec_ch.trigger_count !== want.trigger_count)
          report_mismatch("trigger_count", 64'(rec_ch.trigger_count),
                          64'(want.trigger_count));
        if (rec_ch.last !== want.last)
          report_mismatch("last", 64'(rec_ch.last), 64'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    pkt_ch.valid <= 1'b0;
    pkt_ch.packet <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_startup_gate();
    test_directed_decode();
    test_backpressure();
    test_random_traffic(340, 0, 0, 1'b1, 32'h0000_0000);
    test_random_traffic(340, 67, 0, 1'b0, 32'hFFFF_FFFF);
    test_random_traffic(340, 0, 67, 1'b1, 32'h7FFF_FFFF);
    test_random_traffic(340, 37, 37, 1'b1, $urandom());
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/pxd_pkg.sv
rtl/core/pxd_pkt_if.sv
rtl/core/pxd_rec_if.sv
rtl/core/pxd_cfg_if.sv
rtl/core/pxd_decode.sv
rtl/core/pixel_detector_packet_decoder.sv
tb/sv/tb_pixel_detector_packet_decoder.sv
